FILE: src/u2a_pkg.sv
// Shared types, codes and the code point to ASCII map of the UTF-8 to ASCII block.
// No dependencies; every other file of the block imports this package.
package u2a_pkg;

  localparam int unsigned CpW = 22;

  localparam logic [6:0] CHAR_QMARK = 7'h3F;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  // One decoded code point on its way from the front end to the back end
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           last;
  } u2a_entry_t;

  // Word handed from the decoder to the queue
  typedef struct packed {
    logic       valid;
    u2a_entry_t entry;
  } u2a_push_t;

  // Queue status seen by the input side and the checks
  typedef struct packed {
    logic       full;
    logic [1:0] count;
  } u2a_qstat_t;

  // Map one code point to its ASCII stand-in
  function automatic logic [6:0] u2a_translit(input logic [CpW-1:0] cp);
    logic [6:0] ch;
    ch = CHAR_QMARK;
    if (cp < 22'h80) begin
      ch = cp[6:0];
    end else begin
      case (cp)
        22'h00C0, 22'h00C1, 22'h00C2, 22'h00C3, 22'h00C4, 22'h00C5, 22'h0102,
        22'h1EA0, 22'h1EA2, 22'h1EA4, 22'h1EA6, 22'h1EA8, 22'h1EAA, 22'h1EAC,
        22'h1EAE, 22'h1EB0, 22'h1EB2, 22'h1EB4, 22'h1EB6: ch = 7'h41; // A
        22'h00E0, 22'h00E1, 22'h00E2, 22'h00E3, 22'h00E4, 22'h00E5, 22'h0103,
        22'h1EA1, 22'h1EA3, 22'h1EA5, 22'h1EA7, 22'h1EA9, 22'h1EAB, 22'h1EAD,
        22'h1EAF, 22'h1EB1, 22'h1EB3, 22'h1EB5, 22'h1EB7: ch = 7'h61; // a
        22'h00C8, 22'h00C9, 22'h00CA, 22'h00CB, 22'h1EBA, 22'h1EBC, 22'h1EB8,
        22'h1EBE, 22'h1EC0, 22'h1EC2, 22'h1EC4, 22'h1EC6: ch = 7'h45; // E
        22'h00E8, 22'h00E9, 22'h00EA, 22'h00EB, 22'h1EB9, 22'h1EBB, 22'h1EBD,
        22'h1EBF, 22'h1EC1, 22'h1EC3, 22'h1EC5, 22'h1EC7: ch = 7'h65; // e
        22'h00CC, 22'h00CD, 22'h00CE, 22'h00CF, 22'h0128, 22'h1ECA,
        22'h1EC8: ch = 7'h49; // I
        22'h00EC, 22'h00ED, 22'h00EE, 22'h00EF, 22'h0129, 22'h1ECB,
        22'h1EC9: ch = 7'h69; // i
        22'h00D2, 22'h00D3, 22'h00D4, 22'h00D5, 22'h00D6, 22'h00D8, 22'h01A0,
        22'h1ECC, 22'h1ECE, 22'h1ED0, 22'h1ED2, 22'h1ED4, 22'h1ED6, 22'h1ED8,
        22'h1EDA, 22'h1EDC, 22'h1EDE, 22'h1EE0, 22'h1EE2: ch = 7'h4F; // O
        22'h00F2, 22'h00F3, 22'h00F4, 22'h00F5, 22'h00F6, 22'h00F8, 22'h01A1,
        22'h1ECD, 22'h1ECF, 22'h1ED1, 22'h1ED3, 22'h1ED5, 22'h1ED7, 22'h1ED9,
        22'h1EDB, 22'h1EDD, 22'h1EDF, 22'h1EE1, 22'h1EE3: ch = 7'h6F; // o
        22'h00D9, 22'h00DA, 22'h00DB, 22'h00DC, 22'h0168, 22'h01AF, 22'h1EE4,
        22'h1EE6, 22'h1EE8, 22'h1EEA, 22'h1EEC, 22'h1EEE, 22'h1EF0: ch = 7'h55; // U
        22'h00F9, 22'h00FA, 22'h00FB, 22'h00FC, 22'h0169, 22'h01B0, 22'h1EE5,
        22'h1EE7, 22'h1EE9, 22'h1EEB, 22'h1EED, 22'h1EEF, 22'h1EF1: ch = 7'h75; // u
        22'h00DD, 22'h0178, 22'h1EF2, 22'h1EF6, 22'h1EF8, 22'h1EF4: ch = 7'h59; // Y
        22'h00FD, 22'h00FF, 22'h1EF3, 22'h1EF7, 22'h1EF9, 22'h1EF5: ch = 7'h79; // y
        22'h0110: ch = 7'h44; // D with stroke
        22'h0111: ch = 7'h64; // d with stroke
        22'h00B7: ch = CHAR_SPACE; // middle dot
        default:  ch = CHAR_QMARK;
      endcase
    end
    return ch;
  endfunction

endpackage

FILE: src/utf8_to_ascii_transliterator.sv
// UTF-8 to ASCII transliterator, top level.
// Takes raw UTF-8 text bytes on the in_ stream and gives one ASCII character
// per decoded code point on the out_ stream.
// in_tdata carries the byte, in_tlast marks the final byte of a text; that
// byte always yields exactly one character with out_tlast set, flushing any
// cut-off sequence as its partial value, or as '?' if that byte breaks it.
// Accented Latin and Vietnamese letters become their base letter, the middle
// dot becomes a space, other non-ASCII code points become '?'.
// Each character passes through the queue and then the output register on
// its way to out_. Throughput: one byte per cycle while the queue is not full;
// the decoder updates its sequence state in the cycle a byte is taken.
// A two-entry queue sits between the decoder and the output register, so
// the input keeps accepting while one character waits on a stalled receiver;
// in_tready drops only when the queue is full.
// Reset (rst_n low, synchronous) closes any open sequence and empties the
// queue and output register.
module utf8_to_ascii_transliterator
  import u2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] text_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] ascii_char, [7] zero
  output logic       out_tlast   // last_char
);

  logic       in_acc;
  u2a_push_t  push;
  logic [1:0] pend;
  logic       pop;
  logic       head_valid;
  u2a_entry_t head;
  u2a_qstat_t qstat;
  logic [6:0] out_char;

  assign in_tready = !qstat.full;
  assign in_acc    = in_tvalid && in_tready;
  assign out_tdata = {1'b0, out_char};

  u2a_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_acc),
    .text_byte   (in_tdata),
    .end_of_text (in_tlast),
    .push        (push),
    .pend        (pend)
  );

  u2a_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .stat       (qstat)
  );

  u2a_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_char   (out_char),
    .out_last   (out_tlast),
    .out_ready  (out_tready)
  );

`ifndef SYNTH
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && qstat.count == 2'd2))
    else $error("queue overflow");

  // A final byte always yields a character and closes the sequence
  a_last_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |-> push.valid ##1 (pend == 2'd0))
    else $error("final byte did not flush");

  // A popped entry shows up on the output the next cycle
  a_pop_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("popped entry lost");
`endif

endmodule

FILE: src/u2a_front.sv
// UTF-8 decoder front end: sequence state and code point assembly per byte.
// Depends on u2a_pkg; pushes finished code points into u2a_queue.
module u2a_front
  import u2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output u2a_push_t  push,
  output logic [1:0] pend
);

  logic [1:0]     pend_r, pend_nxt;
  logic [CpW-1:0] acc_r, acc_nxt;
  logic [CpW-1:0] acc_shift;
  logic [1:0]     pend_dec;
  logic [7:0]     lead_mask;
  logic [1:0]     lead_n;

  assign acc_shift = {acc_r[CpW-7:0], text_byte[5:0]};
  assign pend_dec  = pend_r - 2'd1;
  assign pend      = pend_r;

  // Count continuation bytes implied by a lead byte
  always_comb begin
    if (text_byte < 8'hE0) begin
      lead_n = 2'd1;
    end else if (text_byte < 8'hF0) begin
      lead_n = 2'd2;
    end else begin
      lead_n = 2'd3;
    end
    case (lead_n)
      2'd1:    lead_mask = 8'h3F;
      2'd2:    lead_mask = 8'h1F;
      default: lead_mask = 8'h0F;
    endcase
  end

  // Decode one byte
  always_comb begin
    pend_nxt         = pend_r;
    acc_nxt          = acc_r;
    push.valid       = 1'b0;
    push.entry.cp    = '0;
    push.entry.last  = end_of_text;
    if (pend_r == 2'd0) begin
      if (!text_byte[7]) begin
        push.valid    = 1'b1;
        push.entry.cp = {{(CpW-8){1'b0}}, text_byte};
      end else begin
        pend_nxt      = lead_n;
        acc_nxt       = {{(CpW-8){1'b0}}, text_byte & lead_mask};
        push.valid    = end_of_text;
        push.entry.cp = acc_nxt;
      end
    end else if (text_byte[7:6] != 2'b10) begin
      // broken sequence: close it and report a question mark
      push.valid    = 1'b1;
      push.entry.cp = {{(CpW-7){1'b0}}, CHAR_QMARK};
      pend_nxt      = 2'd0;
      acc_nxt       = '0;
    end else begin
      pend_nxt = pend_dec;
      acc_nxt  = acc_shift;
      if (pend_dec == 2'd0 || end_of_text) begin
        push.valid    = 1'b1;
        push.entry.cp = acc_shift;
        pend_nxt      = 2'd0;
        acc_nxt       = '0;
      end
    end
    if (end_of_text) begin
      pend_nxt = 2'd0;
      acc_nxt  = '0;
    end
    push.valid = push.valid & accept;
  end

  // Advance decoder state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      acc_r  <= '0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

FILE: src/u2a_queue.sv
// Two-entry queue between the decoder front end and the mapping back end.
// Depends on u2a_pkg for the entry and status types.
module u2a_queue
  import u2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  u2a_push_t  push,
  input  logic       pop,
  output logic       head_valid,
  output u2a_entry_t head,
  output u2a_qstat_t stat
);

  u2a_entry_t mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_pop;

  assign do_pop     = pop && (cnt_r != 2'd0);
  assign head_valid = (cnt_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (cnt_r == 2'd2);
  assign stat.count = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !do_pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!push.valid && do_pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: src/u2a_back.sv
// Back end: maps queued code points to ASCII and holds the output register.
// Depends on u2a_pkg for the map function and entry type.
module u2a_back
  import u2a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  u2a_entry_t head,
  output logic       pop,
  output logic       out_valid,
  output logic [6:0] out_char,
  output logic       out_last,
  input  logic       out_ready
);

  logic       valid_r;
  logic [6:0] char_r;
  logic       last_r;

  assign pop       = head_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_char  = char_r;
  assign out_last  = last_r;

  // Load a new word when the output register is free or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_r <= u2a_translit(head.cp);
      last_r <= head.last;
    end
  end

endmodule
